FILE: hdl/bse_pkg.sv
// Shared types and constants for the bubble sort block.
`default_nettype none
package bse_pkg;

    // Width of one list element
    localparam int unsigned DATA_W = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_FIRST,
        S_PASS,
        S_TAIL,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

endpackage
`default_nettype wire

FILE: hdl/bse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bse_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: hdl/bubble_sort_early_exit.sv
// Top level: collects a list, bubble sorts it in place in a RAM, streams it out.
//
// Words arrive on the slave stream, one list element each, tlast closing the list;
// up to MAX_ELEMENTS are kept and any beyond are dropped, which sets tuser (overflow)
// on every word of that list's output. Each loaded word is written to the RAM as
// it is accepted. Sorting then runs passes over the RAM with one comparator: a pass
// over n elements does pass setup, one read/compare/write per neighbor pair and
// the write of the carried element, and at most n - 1 passes run; a pass with no
// swap ends the sort early. Output then streams at one word per cycle while the
// master side is ready, after a RAM read start. The slave side is ready only while
// loading; the last output word may still wait in the output register while the
// next list loads. The element RAM needs no clearing after reset.
`default_nettype none
module bubble_sort_early_exit #(
    parameter int unsigned MAX_ELEMENTS = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // slave stream: tdata = element_value[31:0]; tlast = is_final
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [bse_pkg::DATA_W-1:0] i_s_axis_tdata,
    input  wire logic                       i_s_axis_tlast,
    // master stream: tdata = sorted_value[31:0]; tlast = end_of_list
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic      [bse_pkg::DATA_W-1:0] o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    // tuser = overflow[0]
    output logic                            o_m_axis_tuser
);

    localparam int unsigned AW = $clog2(MAX_ELEMENTS);
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);
    localparam logic [CW-1:0] ONE_CNT = CW'(1);
    localparam logic [CW-1:0] TWO_CNT = CW'(2);

    bse_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic          r_drop,  n_drop;
    logic [CW-1:0] r_pass,  n_pass;
    logic          r_swapped, n_swapped;
    logic [AW-1:0] r_k,     n_k;
    logic [bse_pkg::DATA_W-1:0] r_cur, n_cur;

    logic                       r_ovalid, n_ovalid;
    logic [bse_pkg::DATA_W-1:0] r_odata,  n_odata;
    logic                       r_olast,  n_olast;
    logic                       r_ouser,  n_ouser;

    // RAM port signals
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [bse_pkg::DATA_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [bse_pkg::DATA_W-1:0] ram_rdata;

    // Handshake and sequencing terms
    logic          in_acc;
    logic          room;
    logic [CW-1:0] k_ext;
    logic          swap;
    logic          last_cmp;
    logic          last_out;
    logic          out_free;

    assign in_acc   = i_s_axis_tvalid && (r_state == bse_pkg::S_LOAD);
    assign room     = (r_count < MAX_CNT);
    assign k_ext    = {{(CW-AW){1'b0}}, r_k};
    // shared comparator: carried element against the one just read
    assign swap     = ($signed(r_cur) > $signed(ram_rdata));
    assign last_cmp = ((k_ext + TWO_CNT) == r_count);
    assign last_out = ((k_ext + ONE_CNT) == r_count);
    assign out_free = !r_ovalid || i_m_axis_tready;

    bse_ram #(
        .WIDTH (bse_pkg::DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state and register updates
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_drop    = r_drop;
        n_pass    = r_pass;
        n_swapped = r_swapped;
        n_k       = r_k;
        n_cur     = r_cur;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_odata   = r_odata;
        n_olast   = r_olast;
        n_ouser   = r_ouser;
        case (r_state)
            bse_pkg::S_LOAD: begin
                if (in_acc) begin
                    if (room) begin
                        n_count = r_count + ONE_CNT;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_pass = ONE_CNT;
                        n_k    = '0;
                        if (room ? (r_count + ONE_CNT < TWO_CNT) : (r_count < TWO_CNT)) begin
                            n_state = bse_pkg::S_OUT_RD;
                        end else begin
                            n_state = bse_pkg::S_START;
                        end
                    end
                end
            end
            bse_pkg::S_START: begin
                n_swapped = 1'b0;
                n_state   = bse_pkg::S_FIRST;
            end
            bse_pkg::S_FIRST: begin
                n_cur   = ram_rdata;
                n_k     = '0;
                n_state = bse_pkg::S_PASS;
            end
            bse_pkg::S_PASS: begin
                // carry the larger element forward, leave the smaller behind
                if (swap) begin
                    n_swapped = 1'b1;
                end else begin
                    n_cur = ram_rdata;
                end
                if (last_cmp) begin
                    n_state = bse_pkg::S_TAIL;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            bse_pkg::S_TAIL: begin
                n_pass = r_pass + ONE_CNT;
                n_k    = '0;
                if (r_swapped && (r_pass + ONE_CNT < r_count)) begin
                    n_state = bse_pkg::S_START;
                end else begin
                    n_state = bse_pkg::S_OUT_RD;
                end
            end
            bse_pkg::S_OUT_RD: begin
                n_state = bse_pkg::S_OUT_LD;
            end
            bse_pkg::S_OUT_LD: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = ram_rdata;
                    n_olast  = last_out;
                    n_ouser  = r_drop;
                    if (last_out) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = bse_pkg::S_LOAD;
                    end else begin
                        n_k = r_k + AW'(1);
                    end
                end
            end
            default: begin
                n_state = bse_pkg::S_LOAD;
            end
        endcase
    end

    // RAM controls per state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_k;
        ram_wdata = r_cur;
        ram_raddr = r_k;
        case (r_state)
            bse_pkg::S_LOAD: begin
                ram_we    = in_acc && room;
                ram_waddr = r_count[AW-1:0];
                ram_wdata = i_s_axis_tdata;
            end
            bse_pkg::S_START: begin
                ram_raddr = '0;
            end
            bse_pkg::S_FIRST: begin
                ram_raddr = AW'(1);
            end
            bse_pkg::S_PASS: begin
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = swap ? ram_rdata : r_cur;
                ram_raddr = r_k + AW'(2);
            end
            bse_pkg::S_TAIL: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_count - ONE_CNT);
                ram_wdata = r_cur;
            end
            bse_pkg::S_OUT_RD: begin
                ram_raddr = r_k;
            end
            bse_pkg::S_OUT_LD: begin
                // hold the address while the output register is full
                ram_raddr = out_free ? (r_k + AW'(1)) : r_k;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bse_pkg::S_LOAD;
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_drop    <= n_drop;
            r_ovalid  <= n_ovalid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_pass    <= n_pass;
        r_swapped <= n_swapped;
        r_k       <= n_k;
        r_cur     <= n_cur;
        r_odata   <= n_odata;
        r_olast   <= n_olast;
        r_ouser   <= n_ouser;
    end

    assign o_s_axis_tready = (r_state == bse_pkg::S_LOAD);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_ouser;

endmodule
`default_nettype wire
